@@ hdl/slc_pkg.sv @@
// shared types, codes and attribute constants for the segment limit and access check
`default_nettype none
package slc_pkg;

	typedef enum logic [1:0] {
		FAULT_NONE  = 2'd0,
		FAULT_GP    = 2'd1,
		FAULT_STACK = 2'd2,
		FAULT_RSVD  = 2'd3
	} fault_t;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_EXEC  = 2'd2;

	localparam logic [1:0] AW_16 = 2'd0;
	localparam logic [1:0] AW_32 = 2'd1;
	localparam logic [1:0] AW_64 = 2'd2;

	localparam logic [1:0] KIND_NORMAL = 2'd0;
	localparam logic [1:0] KIND_STACK  = 2'd1;
	localparam logic [1:0] KIND_FSGS   = 2'd2;

	localparam logic [16:0] ATTR_EXPDN_MASK   = 17'h0000c;
	localparam logic [16:0] ATTR_EXPDN_VAL    = 17'h00004;
	localparam logic [16:0] ATTR_PRESENT_MASK = 17'h10080;
	localparam logic [16:0] ATTR_PRESENT_VAL  = 17'h00080;
	localparam logic [16:0] ATTR_RW_MASK      = 17'h0000a;
	localparam logic [16:0] ATTR_WRITABLE     = 17'h00002;
	localparam logic [16:0] ATTR_CODE_NOREAD  = 17'h00008;
	localparam int          ATTR_CODE_BIT     = 3;

	localparam int SPAN_W = 49;
	localparam logic [SPAN_W-1:0] CANON_END = SPAN_W'(64'h0001_0000_0000_0000);

	typedef struct packed {
		logic [1:0]  op;
		logic [1:0]  addr_width;
		logic [63:0] offset;
		logic [3:0]  access_bytes;
		logic [1:0]  seg_kind;
		logic [63:0] seg_base;
		logic [31:0] seg_limit;
		logic [16:0] seg_attr;
	} in_item_t;

	typedef struct packed {
		fault_t            fault;
		logic [63:0]       linear_addr;
		logic [SPAN_W-1:0] span;
	} out_item_t;

endpackage
`default_nettype wire

@@ hdl/slc_long_check.sv @@
// sixty-four-bit mode path: fs/gs base add, canonical test and span to the end of the canonical half
`default_nettype none
module slc_long_check
	import slc_pkg::*;
(
	input  wire logic [63:0] offset,
	input  wire logic [1:0]  seg_kind,
	input  wire logic [63:0] seg_base,
	output out_item_t        result
);

	logic [63:0] lin;
	logic        canonical;

	always_comb begin
		lin = (seg_kind == KIND_FSGS) ? offset + seg_base : offset;
		canonical = (lin[63:48] == 16'h0000) || (lin[63:48] == 16'hffff);
		result = '0;
		if (!canonical) begin
			result.fault = FAULT_GP;
		end else begin
			result.fault = FAULT_NONE;
			result.linear_addr = lin;
			// upper half wraps to 2^49 - a, which is the distance to zero
			if (lin[63]) result.span = SPAN_W'(0) - lin[SPAN_W-1:0];
			else         result.span = CANON_END - lin[SPAN_W-1:0];
		end
	end

endmodule
`default_nettype wire

@@ hdl/slc_legacy_check.sv @@
// legacy path: limit test, present/usable test, rights test and 32-bit linear address
`default_nettype none
module slc_legacy_check
	import slc_pkg::*;
(
	input  wire logic [1:0]  op,
	input  wire logic [31:0] offset,
	input  wire logic [3:0]  access_bytes,
	input  wire logic [1:0]  seg_kind,
	input  wire logic [31:0] seg_base,
	input  wire logic [31:0] seg_limit,
	input  wire logic [16:0] seg_attr,
	output out_item_t        result
);

	logic        expand_down;
	logic [32:0] end_excl;
	logic [32:0] limit_excl;
	logic [31:0] last32;
	logic        limit_bad;
	logic        present_bad;
	logic        rights_bad;
	logic [32:0] span_v;
	fault_t      lim_fault;
	logic [31:0] lin32;

	always_comb begin
		expand_down = (seg_attr & ATTR_EXPDN_MASK) == ATTR_EXPDN_VAL;
		lim_fault = (seg_kind == KIND_STACK) ? FAULT_STACK : FAULT_GP;
		end_excl = {1'b0, offset} + {29'd0, access_bytes};
		limit_excl = {1'b0, seg_limit} + 33'd1;
		last32 = offset + {28'd0, access_bytes} - 32'd1;
		if (expand_down) begin
			limit_bad = (last32 < offset) || (offset <= seg_limit);
			span_v = {1'b0, 32'd0 - offset};
		end else begin
			// zero-size access at offset zero wraps below zero and faults
			limit_bad = (end_excl == 33'd0) || (end_excl > limit_excl);
			span_v = limit_excl - {1'b0, offset};
		end
		present_bad = (seg_attr & ATTR_PRESENT_MASK) != ATTR_PRESENT_VAL;
		case (op)
			OP_WRITE: rights_bad = (seg_attr & ATTR_RW_MASK) != ATTR_WRITABLE;
			OP_EXEC:  rights_bad = !seg_attr[ATTR_CODE_BIT];
			default:  rights_bad = (seg_attr & ATTR_RW_MASK) == ATTR_CODE_NOREAD;
		endcase
		lin32 = offset + seg_base;
		result = '0;
		if (limit_bad) begin
			result.fault = lim_fault;
		end else if (present_bad || rights_bad) begin
			result.fault = FAULT_GP;
		end else begin
			result.fault = FAULT_NONE;
			result.linear_addr = {32'd0, lin32};
			result.span = {16'd0, span_v};
		end
	end

endmodule
`default_nettype wire

@@ hdl/segment_limit_access_check_top.sv @@
// top level: input register, segmentation checks, result register
// Each transfer on the input side is checked in a two-register pipeline: the item is
// captured in the input register, the limit, canonical and rights tests run in one
// combinational pass, and the result lands in the output register. Output valid rises when
// the item moves from the input register into the output register, which waits while the
// output register holds an untaken result; one item is accepted every cycle as long as the
// output side takes results, and a stalled output holds one result in the output register
// and one item in the input register before input ready drops. Faulting accesses return
// zero for the linear address and span.
`default_nettype none
module segment_limit_access_check_top
	import slc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_item,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_item_t     out_item
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t item_s2;
	logic      adv_s2;
	logic [63:0] off_trunc;
	out_item_t res_long;
	out_item_t res_legacy;
	out_item_t res_sel;

	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_s1 <= in_item;
	end

	always_comb begin
		case (item_s1.addr_width)
			AW_16:   off_trunc = {48'd0, item_s1.offset[15:0]};
			AW_64:   off_trunc = item_s1.offset;
			default: off_trunc = {32'd0, item_s1.offset[31:0]};
		endcase
	end

	slc_long_check u_long (
		.offset   (off_trunc),
		.seg_kind (item_s1.seg_kind),
		.seg_base (item_s1.seg_base),
		.result   (res_long)
	);

	slc_legacy_check u_legacy (
		.op           (item_s1.op),
		.offset       (off_trunc[31:0]),
		.access_bytes (item_s1.access_bytes),
		.seg_kind     (item_s1.seg_kind),
		.seg_base     (item_s1.seg_base[31:0]),
		.seg_limit    (item_s1.seg_limit),
		.seg_attr     (item_s1.seg_attr),
		.result       (res_legacy)
	);

	assign res_sel = (item_s1.addr_width == AW_64) ? res_long : res_legacy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) item_s2 <= res_sel;
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

	// a faulting result never leaks an address or span
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.fault != FAULT_NONE) |->
			(out_item.linear_addr == 64'd0 && out_item.span == '0))
		else $error("faulting result carries nonzero address or span");

	// input side only stalls when the input and output registers are both occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2))
		else $error("input stalled with free pipeline slot");

	// an item that moves out of the input register shows up at the output next cycle
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> out_valid)
		else $error("advanced item missing from output register");

	// legacy-mode results never carry a linear address above 32 bits
	a_legacy_width: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2 && item_s1.addr_width != AW_64) |=>
			(out_item.linear_addr[63:32] == 32'd0))
		else $error("legacy linear address exceeds 32 bits");

endmodule
`default_nettype wire
